// ===== design/tlbpt_pkg.sv =====
// tlbpt_pkg: constants, entry layouts and codes for the TLB / page table / cache block.
// No dependencies; used by tlb_page_table_cache_model.
`default_nettype none
package tlbpt_pkg;

  // sizing
  localparam int VIRT_BYTES      = 1024;
  localparam int MAX_TLB_ENTRIES = 64;
  localparam int MAX_FRAMES      = 64;
  localparam int MAX_CACHE_SETS  = 64;
  localparam int MAX_WAYS        = 8;

  localparam int VA_W     = $clog2(VIRT_BYTES);
  localparam int PT_DEPTH = VIRT_BYTES / 4;
  localparam int VPN_W    = $clog2(PT_DEPTH);
  localparam int TLB_W    = $clog2(MAX_TLB_ENTRIES);
  localparam int FRAME_W  = $clog2(MAX_FRAMES);
  localparam int SET_W    = $clog2(MAX_CACHE_SETS);
  localparam int WAY_W    = $clog2(MAX_WAYS);
  localparam int STAMP_W  = 32;
  localparam int PA_W     = FRAME_W + VPN_W;
  localparam int TAG_W    = PA_W;

  // register indexes
  localparam logic [2:0] REG_I_PAGE  = 3'd0;
  localparam logic [2:0] REG_D_PAGE  = 3'd1;
  localparam logic [2:0] REG_I_FRAME = 3'd2;
  localparam logic [2:0] REG_D_FRAME = 3'd3;
  localparam logic [2:0] REG_I_GEOM  = 3'd4;
  localparam logic [2:0] REG_D_GEOM  = 3'd5;

  // page table result codes
  localparam logic [1:0] PT_NONE  = 2'd0;
  localparam logic [1:0] PT_HIT   = 2'd1;
  localparam logic [1:0] PT_FAULT = 2'd2;

  typedef struct packed {
    logic [VPN_W-1:0]   page;
    logic [FRAME_W-1:0] frame;
    logic [STAMP_W-1:0] stamp;
  } tlb_entry_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pt_entry_t;

  typedef struct packed {
    logic             valid;
    logic             mru;
    logic [TAG_W-1:0] tag;
  } line_t;

endpackage
`default_nettype wire

// ===== design/tlb_page_table_cache_model.sv =====
// tlb_page_table_cache_model: two-sided address translation (TLB, page table, FIFO frames)
// followed by a bit-PLRU set-associative cache lookup. Depends on tlbpt_pkg.
`default_nettype none

// One word is worked on at a time. A TLB hit ends the TLB scan at the hitting entry and
// goes on to the cache lookup; a miss scans all TLB entries, reads the page table, and on
// a fault with no free frame also scans frame stamps, the page table, the TLB again and
// every cache line of the victim page (each block and way). The state sits in single-port-
// read memories with a registered read; every step is a read followed by a compare/write.
// After reset the page table and cache line memories of both sides are swept clean; a
// configuration write sweeps its side. No word is accepted during a sweep.
module tlb_page_table_cache_model (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [47:0] in_tdata,   // [9:0] virtual_address, [41:10] time_stamp
  input  wire logic        in_tuser,   // [0] side
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [9:0] physical_address, [10] tlb_hit,
                                       // [12:11] page_table_result, [13] cache_hit
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_addr,
  input  wire logic [11:0] cfg_wdata
);

  localparam int VA_W    = tlbpt_pkg::VA_W;
  localparam int VPN_W   = tlbpt_pkg::VPN_W;
  localparam int TLB_W   = tlbpt_pkg::TLB_W;
  localparam int FRAME_W = tlbpt_pkg::FRAME_W;
  localparam int SET_W   = tlbpt_pkg::SET_W;
  localparam int WAY_W   = tlbpt_pkg::WAY_W;
  localparam int STAMP_W = tlbpt_pkg::STAMP_W;
  localparam int PA_W    = tlbpt_pkg::PA_W;
  localparam int TAG_W   = tlbpt_pkg::TAG_W;
  localparam int NWAY    = tlbpt_pkg::MAX_WAYS;
  localparam int NTLB    = tlbpt_pkg::MAX_TLB_ENTRIES;
  localparam int NFRM    = tlbpt_pkg::MAX_FRAMES;
  localparam int LINE_AW = 1 + SET_W + WAY_W;
  localparam int CLR_W   = SET_W + WAY_W;

  // states
  localparam logic [4:0] S_CLEAR    = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_TLB_RD   = 5'd2;
  localparam logic [4:0] S_TLB_CMP  = 5'd3;
  localparam logic [4:0] S_PT_RD    = 5'd4;
  localparam logic [4:0] S_PT_CMP   = 5'd5;
  localparam logic [4:0] S_FR_RD    = 5'd6;
  localparam logic [4:0] S_FR_CMP   = 5'd7;
  localparam logic [4:0] S_EPT_RD   = 5'd8;
  localparam logic [4:0] S_EPT_CMP  = 5'd9;
  localparam logic [4:0] S_ETLB_RD  = 5'd10;
  localparam logic [4:0] S_ETLB_CMP = 5'd11;
  localparam logic [4:0] S_EL_RD    = 5'd12;
  localparam logic [4:0] S_EL_CMP   = 5'd13;
  localparam logic [4:0] S_ALLOC    = 5'd14;
  localparam logic [4:0] S_FILL     = 5'd15;
  localparam logic [4:0] S_C_RD     = 5'd16;
  localparam logic [4:0] S_C_CMP    = 5'd17;
  localparam logic [4:0] S_C_UPD    = 5'd18;
  localparam logic [4:0] S_C_WR     = 5'd19;
  localparam logic [4:0] S_DONE     = 5'd20;

  // memories
  tlbpt_pkg::tlb_entry_t tlb_mem  [2*NTLB];
  tlbpt_pkg::pt_entry_t  pt_mem   [2*tlbpt_pkg::PT_DEPTH];
  logic [STAMP_W-1:0]    fs_mem   [2*NFRM];
  tlbpt_pkg::line_t      line_mem [2*tlbpt_pkg::MAX_CACHE_SETS*NWAY];

  logic                      tlb_we;
  logic [TLB_W:0]            tlb_waddr, tlb_raddr;
  tlbpt_pkg::tlb_entry_t     tlb_wdata, tlb_rd_r;
  logic                      pt_we;
  logic [VPN_W:0]            pt_waddr, pt_raddr;
  tlbpt_pkg::pt_entry_t      pt_wdata, pt_rd_r;
  logic                      fs_we;
  logic [FRAME_W:0]          fs_waddr, fs_raddr;
  logic [STAMP_W-1:0]        fs_wdata, fs_rd_r;
  logic                      line_we;
  logic [LINE_AW-1:0]        line_waddr, line_raddr;
  tlbpt_pkg::line_t          line_wdata, line_rd_r;

  // registers
  logic [4:0]          state_r, state_nxt;
  logic                side_r, side_nxt;
  logic [VA_W-1:0]     va_r, va_nxt;
  logic [STAMP_W-1:0]  now_r, now_nxt;
  logic [VPN_W-1:0]    idx_r, idx_nxt;
  logic [WAY_W-1:0]    w_r, w_nxt;
  logic [VPN_W:0]      bi_r, bi_nxt;
  logic [STAMP_W-1:0]  min_stamp_r, min_stamp_nxt;
  logic [TLB_W-1:0]    min_idx_r, min_idx_nxt;
  logic [STAMP_W-1:0]  fmin_r, fmin_nxt;
  logic [FRAME_W-1:0]  fpick_r, fpick_nxt;
  logic [FRAME_W-1:0]  frame_r, frame_nxt;
  logic                tlb_hit_r, tlb_hit_nxt;
  logic [1:0]          ptres_r, ptres_nxt;
  logic                chit_r, chit_nxt;
  logic [NWAY-1:0]     lv_r, lv_nxt, lm_r, lm_nxt;
  logic [TAG_W-1:0]    lt_r [NWAY];
  logic [TAG_W-1:0]    lt_nxt [NWAY];
  logic                out_valid_r, out_valid_nxt;
  logic [15:0]         out_data_r, out_data_nxt;
  logic [CLR_W-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic                clr_side_r, clr_side_nxt;
  logic                clr_both_r, clr_both_nxt;
  logic [3:0]          i_page_r, i_page_nxt, d_page_r, d_page_nxt;
  logic [2:0]          i_frame_r, i_frame_nxt, d_frame_r, d_frame_nxt;
  logic [11:0]         i_geom_r, i_geom_nxt, d_geom_r, d_geom_nxt;
  logic [2*NTLB-1:0]   tlb_valid_r, tlb_valid_nxt;
  logic [2*NFRM-1:0]   frame_used_r, frame_used_nxt;

  // per-side geometry
  logic [3:0]          page_log, pb, bb;
  logic [2:0]          frame_log, fbits, sbits;
  logic [11:0]         geom;
  logic [1:0]          wbits;
  logic [TLB_W:0]      n_tlb;
  logic [VPN_W:0]      pages, page_bytes, step;
  logic [FRAME_W:0]    fc;
  logic [WAY_W:0]      ways;
  logic [VPN_W-1:0]    vpn;
  logic [VA_W-1:0]     va_mask;
  logic [PA_W-1:0]     pa, blk_c, pa_e, blk_e, set_mask;
  logic [SET_W-1:0]    set_c, set_e;
  logic [TAG_W-1:0]    tag_c, tag_e;

  always_comb begin
    page_log  = side_r ? d_page_r : i_page_r;
    frame_log = side_r ? d_frame_r : i_frame_r;
    geom      = side_r ? d_geom_r : i_geom_r;
    if (page_log < 4'd2) begin
      pb = 4'd2;
    end else if (page_log > 4'd8) begin
      pb = 4'd8;
    end else begin
      pb = page_log;
    end
    n_tlb      = (TLB_W+1)'(1) << (4'd8 - pb);
    pages      = (VPN_W+1)'(1) << (4'd10 - pb);
    page_bytes = (VPN_W+1)'(1) << pb;
    fbits      = (frame_log > 3'd6) ? 3'd6 : frame_log;
    fc         = (FRAME_W+1)'(1) << fbits;
    bb         = geom[3:0];
    sbits      = (geom[7:4] > 4'd6) ? 3'd6 : geom[6:4];
    wbits      = (geom[11:8] > 4'd3) ? 2'd3 : geom[9:8];
    ways       = (WAY_W+1)'(1) << wbits;
    step       = (bb < pb) ? ((VPN_W+1)'(1) << bb) : page_bytes;
    vpn        = VPN_W'(va_r >> pb);
    va_mask    = (VA_W'(1) << pb) - VA_W'(1);
    set_mask   = (PA_W'(1) << sbits) - PA_W'(1);
    // lookup address
    pa         = (PA_W'(frame_r) << pb) + PA_W'(va_r & va_mask);
    blk_c      = pa >> bb;
    set_c      = SET_W'(blk_c & set_mask);
    tag_c      = blk_c >> sbits;
    // eviction sweep address
    pa_e       = (PA_W'(fpick_r) << pb) + PA_W'(bi_r);
    blk_e      = pa_e >> bb;
    set_e      = SET_W'(blk_e & set_mask);
    tag_e      = blk_e >> sbits;
  end

  // first invalid TLB entry and first free frame
  logic               tf_found, ff_found;
  logic [TLB_W-1:0]   tf_idx;
  logic [FRAME_W-1:0] ff_idx;

  always_comb begin
    tf_found = 1'b0;
    tf_idx   = '0;
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = 0; i < NTLB; i++) begin
      if (i < int'(n_tlb) && !tf_found && !tlb_valid_r[{side_r, TLB_W'(i)}]) begin
        tf_found = 1'b1;
        tf_idx   = TLB_W'(i);
      end
    end
    for (int i = 0; i < NFRM; i++) begin
      if (i < int'(fc) && !ff_found && !frame_used_r[{side_r, FRAME_W'(i)}]) begin
        ff_found = 1'b1;
        ff_idx   = FRAME_W'(i);
      end
    end
  end

  // PLRU update of the gathered set
  logic [NWAY-1:0]  cu_v, cu_m;
  logic [TAG_W-1:0] cu_t [NWAY];
  logic             cu_hit, cu_free, cu_all1;
  logic [WAY_W-1:0] cu_way;

  always_comb begin
    cu_v    = lv_r;
    cu_m    = lm_r;
    cu_t    = lt_r;
    cu_hit  = 1'b0;
    cu_free = 1'b0;
    cu_all1 = 1'b1;
    cu_way  = '0;
    for (int w = 0; w < NWAY; w++) begin
      if (w < int'(ways) && !cu_hit && lv_r[w] && lt_r[w] == tag_c) begin
        cu_hit = 1'b1;
        cu_way = WAY_W'(w);
      end
    end
    if (!cu_hit && ways > (WAY_W+1)'(1)) begin
      for (int w = 0; w < NWAY; w++) begin
        if (w < int'(ways) && !cu_free && !(lv_r[w] && lm_r[w])) begin
          cu_free = 1'b1;
          cu_way  = WAY_W'(w);
        end
      end
    end
    if (!cu_hit) begin
      cu_v[cu_way] = 1'b1;
      cu_t[cu_way] = tag_c;
    end
    cu_m[cu_way] = 1'b1;
    for (int w = 0; w < NWAY; w++) begin
      if (w < int'(ways) && !(cu_v[w] && cu_m[w])) cu_all1 = 1'b0;
    end
    // all-ones collapses to the touched way
    if (cu_all1 && (cu_hit || ways > (WAY_W+1)'(1))) begin
      for (int w = 0; w < NWAY; w++) begin
        if (w < int'(ways)) cu_m[w] = (WAY_W'(w) == cu_way);
      end
    end
  end

  // read addresses
  always_comb begin
    tlb_raddr  = {side_r, idx_r[TLB_W-1:0]};
    pt_raddr   = (state_r == S_PT_RD) ? {side_r, vpn} : {side_r, idx_r};
    fs_raddr   = {side_r, idx_r[FRAME_W-1:0]};
    line_raddr = (state_r == S_EL_RD) ? {side_r, set_e, w_r} : {side_r, set_c, w_r};
  end

  // sequencer
  logic       cfg_side;
  logic [TLB_W-1:0] fill_idx;

  always_comb begin
    state_nxt      = state_r;
    side_nxt       = side_r;
    va_nxt         = va_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    w_nxt          = w_r;
    bi_nxt         = bi_r;
    min_stamp_nxt  = min_stamp_r;
    min_idx_nxt    = min_idx_r;
    fmin_nxt       = fmin_r;
    fpick_nxt      = fpick_r;
    frame_nxt      = frame_r;
    tlb_hit_nxt    = tlb_hit_r;
    ptres_nxt      = ptres_r;
    chit_nxt       = chit_r;
    lv_nxt         = lv_r;
    lm_nxt         = lm_r;
    lt_nxt         = lt_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_side_nxt   = clr_side_r;
    clr_both_nxt   = clr_both_r;
    i_page_nxt     = i_page_r;
    d_page_nxt     = d_page_r;
    i_frame_nxt    = i_frame_r;
    d_frame_nxt    = d_frame_r;
    i_geom_nxt     = i_geom_r;
    d_geom_nxt     = d_geom_r;
    tlb_valid_nxt  = tlb_valid_r;
    frame_used_nxt = frame_used_r;
    tlb_we         = 1'b0;
    tlb_waddr      = {side_r, idx_r[TLB_W-1:0]};
    tlb_wdata      = tlb_rd_r;
    pt_we          = 1'b0;
    pt_waddr       = {side_r, idx_r};
    pt_wdata       = '0;
    fs_we          = 1'b0;
    fs_waddr       = {side_r, fpick_r};
    fs_wdata       = now_r;
    line_we        = 1'b0;
    line_waddr     = {side_r, set_c, w_r};
    line_wdata     = '0;
    cfg_side       = cfg_addr[0];
    fill_idx       = tf_found ? tf_idx : min_idx_r;

    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      // sweep page table and cache lines of one or both sides
      S_CLEAR: begin
        pt_we      = (clr_cnt_r < CLR_W'(tlbpt_pkg::PT_DEPTH));
        pt_waddr   = {clr_side_r, clr_cnt_r[VPN_W-1:0]};
        line_we    = 1'b1;
        line_waddr = {clr_side_r, clr_cnt_r};
        if (clr_cnt_r == '1) begin
          clr_cnt_nxt = '0;
          if (clr_both_r && !clr_side_r) begin
            clr_side_nxt = 1'b1;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_cnt_nxt = clr_cnt_r + CLR_W'(1);
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          side_nxt  = in_tuser;
          va_nxt    = in_tdata[VA_W-1:0];
          now_nxt   = in_tdata[VA_W +: STAMP_W];
          idx_nxt   = '0;
          state_nxt = S_TLB_RD;
        end
      end
      S_TLB_RD: state_nxt = S_TLB_CMP;
      // TLB search, tracking the oldest stamp for a later fill
      S_TLB_CMP: begin
        if (tlb_valid_r[{side_r, idx_r[TLB_W-1:0]}] && tlb_rd_r.page == vpn) begin
          tlb_we      = 1'b1;
          tlb_wdata   = '{page: tlb_rd_r.page, frame: tlb_rd_r.frame, stamp: now_r};
          frame_nxt   = tlb_rd_r.frame;
          tlb_hit_nxt = 1'b1;
          ptres_nxt   = tlbpt_pkg::PT_NONE;
          w_nxt       = '0;
          state_nxt   = S_C_RD;
        end else begin
          if (idx_r == '0 || tlb_rd_r.stamp < min_stamp_r) begin
            min_stamp_nxt = tlb_rd_r.stamp;
            min_idx_nxt   = idx_r[TLB_W-1:0];
          end
          if (idx_r == VPN_W'(n_tlb - (TLB_W+1)'(1))) begin
            tlb_hit_nxt = 1'b0;
            state_nxt   = S_PT_RD;
          end else begin
            idx_nxt   = idx_r + VPN_W'(1);
            state_nxt = S_TLB_RD;
          end
        end
      end
      S_PT_RD: state_nxt = S_PT_CMP;
      S_PT_CMP: begin
        if (pt_rd_r.valid) begin
          frame_nxt = pt_rd_r.frame;
          ptres_nxt = tlbpt_pkg::PT_HIT;
          state_nxt = S_FILL;
        end else begin
          ptres_nxt = tlbpt_pkg::PT_FAULT;
          if (ff_found) begin
            fpick_nxt = ff_idx;
            state_nxt = S_ALLOC;
          end else begin
            idx_nxt   = '0;
            state_nxt = S_FR_RD;
          end
        end
      end
      S_FR_RD: state_nxt = S_FR_CMP;
      // oldest allocated frame is the victim
      S_FR_CMP: begin
        if (idx_r == '0 || fs_rd_r < fmin_r) begin
          fmin_nxt  = fs_rd_r;
          fpick_nxt = idx_r[FRAME_W-1:0];
        end
        if (idx_r == VPN_W'(fc - (FRAME_W+1)'(1))) begin
          idx_nxt   = '0;
          state_nxt = S_EPT_RD;
        end else begin
          idx_nxt   = idx_r + VPN_W'(1);
          state_nxt = S_FR_RD;
        end
      end
      S_EPT_RD: state_nxt = S_EPT_CMP;
      // drop the first page mapped to the victim
      S_EPT_CMP: begin
        if (pt_rd_r.valid && pt_rd_r.frame == fpick_r) begin
          pt_we     = 1'b1;
          idx_nxt   = '0;
          state_nxt = S_ETLB_RD;
        end else if (idx_r == VPN_W'(pages - (VPN_W+1)'(1))) begin
          idx_nxt   = '0;
          state_nxt = S_ETLB_RD;
        end else begin
          idx_nxt   = idx_r + VPN_W'(1);
          state_nxt = S_EPT_RD;
        end
      end
      S_ETLB_RD: state_nxt = S_ETLB_CMP;
      S_ETLB_CMP: begin
        if (tlb_valid_r[{side_r, idx_r[TLB_W-1:0]}] && tlb_rd_r.frame == fpick_r) begin
          tlb_valid_nxt[{side_r, idx_r[TLB_W-1:0]}] = 1'b0;
        end
        if (idx_r == VPN_W'(n_tlb - (TLB_W+1)'(1))) begin
          bi_nxt    = '0;
          w_nxt     = '0;
          state_nxt = S_EL_RD;
        end else begin
          idx_nxt   = idx_r + VPN_W'(1);
          state_nxt = S_ETLB_RD;
        end
      end
      S_EL_RD: state_nxt = S_EL_CMP;
      // invalidate cached blocks of the victim page
      S_EL_CMP: begin
        if (line_rd_r.valid && line_rd_r.tag == tag_e) begin
          line_we    = 1'b1;
          line_waddr = {side_r, set_e, w_r};
          line_wdata = '{valid: 1'b0, mru: 1'b0, tag: line_rd_r.tag};
        end
        if (w_r == WAY_W'(ways - (WAY_W+1)'(1))) begin
          w_nxt = '0;
          if ((VPN_W+2)'(bi_r) + (VPN_W+2)'(step) >= (VPN_W+2)'(page_bytes)) begin
            state_nxt = S_ALLOC;
          end else begin
            bi_nxt    = bi_r + step;
            state_nxt = S_EL_RD;
          end
        end else begin
          w_nxt     = w_r + WAY_W'(1);
          state_nxt = S_EL_RD;
        end
      end
      S_ALLOC: begin
        frame_used_nxt[{side_r, fpick_r}] = 1'b1;
        fs_we     = 1'b1;
        pt_we     = 1'b1;
        pt_waddr  = {side_r, vpn};
        pt_wdata  = '{valid: 1'b1, frame: fpick_r};
        frame_nxt = fpick_r;
        state_nxt = S_FILL;
      end
      S_FILL: begin
        tlb_we    = 1'b1;
        tlb_waddr = {side_r, fill_idx};
        tlb_wdata = '{page: vpn, frame: frame_r, stamp: now_r};
        tlb_valid_nxt[{side_r, fill_idx}] = 1'b1;
        w_nxt     = '0;
        state_nxt = S_C_RD;
      end
      S_C_RD: state_nxt = S_C_CMP;
      // gather the set
      S_C_CMP: begin
        lv_nxt[w_r] = line_rd_r.valid;
        lm_nxt[w_r] = line_rd_r.mru;
        lt_nxt[w_r] = line_rd_r.tag;
        if (w_r == WAY_W'(ways - (WAY_W+1)'(1))) begin
          state_nxt = S_C_UPD;
        end else begin
          w_nxt     = w_r + WAY_W'(1);
          state_nxt = S_C_RD;
        end
      end
      S_C_UPD: begin
        lv_nxt    = cu_v;
        lm_nxt    = cu_m;
        lt_nxt    = cu_t;
        chit_nxt  = cu_hit;
        w_nxt     = '0;
        state_nxt = S_C_WR;
      end
      // write the set back
      S_C_WR: begin
        line_we    = 1'b1;
        line_wdata = '{valid: lv_r[w_r], mru: lm_r[w_r], tag: lt_r[w_r]};
        if (w_r == WAY_W'(ways - (WAY_W+1)'(1))) begin
          state_nxt = S_DONE;
        end else begin
          w_nxt = w_r + WAY_W'(1);
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {2'b00, chit_r, ptres_r, tlb_hit_r, pa[VA_W-1:0]};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // register write flushes its side
    if (cfg_we && cfg_addr <= tlbpt_pkg::REG_D_GEOM) begin
      unique case (cfg_addr)
        tlbpt_pkg::REG_I_PAGE:  i_page_nxt  = cfg_wdata[3:0];
        tlbpt_pkg::REG_D_PAGE:  d_page_nxt  = cfg_wdata[3:0];
        tlbpt_pkg::REG_I_FRAME: i_frame_nxt = cfg_wdata[2:0];
        tlbpt_pkg::REG_D_FRAME: d_frame_nxt = cfg_wdata[2:0];
        tlbpt_pkg::REG_I_GEOM:  i_geom_nxt  = cfg_wdata;
        default:                d_geom_nxt  = cfg_wdata;
      endcase
      for (int i = 0; i < NTLB; i++) tlb_valid_nxt[{cfg_side, TLB_W'(i)}] = 1'b0;
      for (int i = 0; i < NFRM; i++) frame_used_nxt[{cfg_side, FRAME_W'(i)}] = 1'b0;
      state_nxt   = S_CLEAR;
      clr_cnt_nxt = '0;
      if (state_r == S_CLEAR && (clr_both_r || clr_side_r != cfg_side)) begin
        clr_side_nxt = 1'b0;
        clr_both_nxt = 1'b1;
      end else begin
        clr_side_nxt = cfg_side;
        clr_both_nxt = 1'b0;
      end
    end
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (tlb_we) tlb_mem[tlb_waddr] <= tlb_wdata;
    tlb_rd_r <= tlb_mem[tlb_raddr];
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_rd_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (fs_we) fs_mem[fs_waddr] <= fs_wdata;
    fs_rd_r <= fs_mem[fs_raddr];
  end

  always_ff @(posedge clk) begin
    if (line_we) line_mem[line_waddr] <= line_wdata;
    line_rd_r <= line_mem[line_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      out_valid_r  <= 1'b0;
      clr_cnt_r    <= '0;
      clr_side_r   <= 1'b0;
      clr_both_r   <= 1'b1;
      i_page_r     <= 4'd3;
      d_page_r     <= 4'd4;
      i_frame_r    <= 3'd3;
      d_frame_r    <= 3'd1;
      i_geom_r     <= 12'd514;
      d_geom_r     <= 12'd34;
      tlb_valid_r  <= '0;
      frame_used_r <= '0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_side_r   <= clr_side_nxt;
      clr_both_r   <= clr_both_nxt;
      i_page_r     <= i_page_nxt;
      d_page_r     <= d_page_nxt;
      i_frame_r    <= i_frame_nxt;
      d_frame_r    <= d_frame_nxt;
      i_geom_r     <= i_geom_nxt;
      d_geom_r     <= d_geom_nxt;
      tlb_valid_r  <= tlb_valid_nxt;
      frame_used_r <= frame_used_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    side_r      <= side_nxt;
    va_r        <= va_nxt;
    now_r       <= now_nxt;
    idx_r       <= idx_nxt;
    w_r         <= w_nxt;
    bi_r        <= bi_nxt;
    min_stamp_r <= min_stamp_nxt;
    min_idx_r   <= min_idx_nxt;
    fmin_r      <= fmin_nxt;
    fpick_r     <= fpick_nxt;
    frame_r     <= frame_nxt;
    tlb_hit_r   <= tlb_hit_nxt;
    ptres_r     <= ptres_nxt;
    chit_r      <= chit_nxt;
    lv_r        <= lv_nxt;
    lm_r        <= lm_nxt;
    lt_r        <= lt_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire
